@@ rtl/osm_pkg.sv @@
// Shared types and constants for the order statistic multiset.
`default_nettype none
package osm_pkg;

	localparam int KeyWidth  = 32;
	localparam int RankWidth = 11;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic signed [KeyWidth-1:0] key_t;

	typedef struct packed {
		logic insert;
		key_t key;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/osm_cell.sv @@
// One cell of the sorted key chain, with its stage of the readout chain.
`default_nettype none
module osm_cell
	import osm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      occupied,
	input  wire logic      at_end,
	input  wire logic      sel,
	input  wire key_t      prev_key,
	input  wire logic      prev_gt,
	input  wire key_t      next_rd_data,
	input  wire logic      next_rd_valid,
	output key_t           key,
	output logic           gt,
	output key_t           rd_data,
	output logic           rd_valid
);

	key_t key_q;
	key_t rd_data_q;
	logic rd_valid_q;

	assign gt = occupied && (key_q > ctl.key);

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_gt) begin
				key_q <= prev_key;
			end else if (gt || at_end) begin
				key_q <= ctl.key;
			end
		end
		rd_data_q <= sel ? key_q : next_rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= sel | next_rd_valid;
		end
	end

	assign key      = key_q;
	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule
`default_nettype wire

@@ rtl/order_statistic_multiset.sv @@
// Top level of the order statistic multiset built as a sorted chain of cells.
`default_nettype none
// An insert transaction's result appears with done on the next cycle; a full
// store drops the key and reports the full status. A query for rank k walks
// the selected key down the readout chain one cell per cycle, and busy stays
// high until its result appears with done. Out-of-range queries answer on the
// next cycle. The receiver cannot stall: each result is on the ports for
// exactly one cycle with done.
module order_statistic_multiset
	import osm_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        action,
	input  wire logic signed [KeyWidth-1:0]  key_value,
	input  wire logic        [RankWidth-1:0] query_rank,
	output logic                             done,
	output logic             [1:0]           status,
	output logic signed      [KeyWidth-1:0]  rank_value
);

	localparam int CountWidth = $clog2(CAPACITY + 1);

	logic [CountWidth-1:0] count_q;
	logic                  busy_q;
	logic                  done_q;
	status_t               status_q;
	key_t                  rank_value_q;

	logic      accept;
	logic      is_full;
	logic      rank_bad;
	logic      do_insert;
	logic      do_query;
	cell_ctl_t ctl;

	key_t key_w     [CAPACITY];
	logic gt_w      [CAPACITY];
	key_t rd_data_w [CAPACITY];
	logic rd_valid_w[CAPACITY];

	assign accept    = start && !busy_q;
	assign is_full   = 32'(count_q) >= 32'(CAPACITY);
	assign rank_bad  = (query_rank == '0) || (32'(query_rank) > 32'(count_q));
	assign do_insert = accept && (action == ACT_INSERT) && !is_full;
	assign do_query  = accept && (action == ACT_QUERY) && !rank_bad;

	assign ctl.insert = do_insert;
	assign ctl.key    = key_value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		key_t prev_key;
		logic prev_gt;
		key_t next_rd_data;
		logic next_rd_valid;

		if (i == 0) begin : g_first
			assign prev_key = '0;
			assign prev_gt  = 1'b0;
		end else begin : g_mid
			assign prev_key = key_w[i-1];
			assign prev_gt  = gt_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_rd_data  = '0;
			assign next_rd_valid = 1'b0;
		end else begin : g_inner
			assign next_rd_data  = rd_data_w[i+1];
			assign next_rd_valid = rd_valid_w[i+1];
		end

		osm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.occupied     (32'(count_q) > 32'(i)),
			.at_end       (32'(count_q) == 32'(i)),
			.sel          (do_query && (32'(query_rank) == 32'(i + 1))),
			.prev_key     (prev_key),
			.prev_gt      (prev_gt),
			.next_rd_data (next_rd_data),
			.next_rd_valid(next_rd_valid),
			.key          (key_w[i]),
			.gt           (gt_w[i]),
			.rd_data      (rd_data_w[i]),
			.rd_valid     (rd_valid_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + 1'b1;
			end
			if (rd_valid_w[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= accept && !do_query;
				if (do_query) begin
					busy_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_w[0]) begin
			status_q     <= ST_OK;
			rank_value_q <= rd_data_w[0];
		end else if (accept) begin
			rank_value_q <= '0;
			if (action == ACT_INSERT) begin
				status_q <= is_full ? ST_FULL : ST_OK;
			end else begin
				status_q <= ST_RANGE;
			end
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign status     = status_q;
	assign rank_value = rank_value_q;

endmodule
`default_nettype wire
